/* rtl/gsa_pkg.sv */
package gsa_pkg;

  localparam int SYM_W   = 8;
  localparam int SCORE_W = 15;
  // Working width for scores: one extra bit of headroom for sums and compares.
  localparam int ACC_W   = 16;
  localparam int KIND_W  = 3;
  localparam int ACT_W   = 2;
  localparam int REG_W   = 8;
  localparam int IDX_W   = 2;

  typedef logic        [SYM_W-1:0]   sym_t;
  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic        [KIND_W-1:0]  kind_t;
  typedef logic        [ACT_W-1:0]   act_t;

  localparam act_t ACT_APPEND_A = 2'd0;
  localparam act_t ACT_APPEND_B = 2'd1;
  localparam act_t ACT_RUN      = 2'd2;

  localparam kind_t KIND_MATCH    = 3'd0;
  localparam kind_t KIND_MISMATCH = 3'd1;
  localparam kind_t KIND_GAP_A    = 3'd2;
  localparam kind_t KIND_GAP_B    = 3'd3;
  localparam kind_t KIND_EMPTY    = 3'd4;

  localparam logic [IDX_W-1:0] REG_GAP      = 2'd0;
  localparam logic [IDX_W-1:0] REG_MISMATCH = 2'd1;
  localparam logic [IDX_W-1:0] REG_MATCH    = 2'd2;

  // Operands of the shared scoring unit.
  typedef struct packed {
    sym_t              a_sym;
    sym_t              b_sym;
    acc_t              diag;
    acc_t              left;
    acc_t              up;
    acc_t              cur;
    logic [REG_W-1:0]  gap;
    logic [REG_W-1:0]  mismatch;
    logic [REG_W-1:0]  bonus;
  } unit_op_t;

  // Results of the shared scoring unit.
  typedef struct packed {
    acc_t best;
    logic diag_hit;
    logic up_hit;
    logic same;
  } unit_res_t;

endpackage

/* rtl/gsa_if.sv */
interface gsa_item_if;
  logic               valid;
  logic               ready;
  gsa_pkg::act_t      action;
  gsa_pkg::sym_t      symbol;

  modport source (output valid, output action, output symbol, input ready);
  modport sink   (input valid, input action, input symbol, output ready);
endinterface

interface gsa_result_if;
  logic               valid;
  logic               ready;
  gsa_pkg::kind_t     kind;
  gsa_pkg::sym_t      matched_symbol;
  gsa_pkg::score_t    score;
  logic               last;

  modport source (output valid, output kind, output matched_symbol, output score,
                  output last, input ready);
  modport sink   (input valid, input kind, input matched_symbol, input score,
                  input last, output ready);
endinterface

/* rtl/gsa_ram.sv */
module gsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/gsa_unit.sv */
module gsa_unit (
  input  gsa_pkg::unit_op_t  op,
  output gsa_pkg::unit_res_t res
);

  gsa_pkg::acc_t gap_x;
  gsa_pkg::acc_t pair;
  gsa_pkg::acc_t dsum;
  gsa_pkg::acc_t lsum;
  gsa_pkg::acc_t usum;
  gsa_pkg::acc_t best;
  logic          same;

  always_comb begin
    same  = (op.a_sym == op.b_sym);
    gap_x = gsa_pkg::acc_t'({1'b0, op.gap});
    pair  = same ? gsa_pkg::acc_t'({1'b0, op.bonus})
                 : -gsa_pkg::acc_t'({1'b0, op.mismatch});
    dsum  = op.diag + pair;
    lsum  = op.left - gap_x;
    usum  = op.up - gap_x;
    best  = dsum;
    if (lsum > best) begin
      best = lsum;
    end
    if (usum > best) begin
      best = usum;
    end
    res.best     = best;
    res.diag_hit = (dsum == op.cur);
    res.up_hit   = (usum == op.cur);
    res.same     = same;
  end

endmodule

/* rtl/global_sequence_alignment_core.sv */
// Global alignment of two byte sequences (Needleman-Wunsch, linear gap cost).
// Words on the item channel append a byte to sequence A or B (bytes past
// MAX_LEN are dropped) or start an alignment. A run fills the (len_a+1) x
// (len_b+1) score grid held in one RAM, one cell per cycle, with a single
// shared scoring unit; the fill rate is bounded by the grid RAM's one read
// and one write per cycle. The traceback then walks from the bottom-right
// corner; each diagonal, up or left step passes through S_TB, S_TB_D and
// S_TB_U (two grid reads in turn through the same port), each step along the
// border through S_TB alone, preferring diagonal, then up, then left. The
// alignment is finally sent left to right, each result word through S_EMIT_RD
// and S_EMIT, where S_EMIT waits out any stall on the result channel. The
// item channel is not ready while a run is in progress, but appends are taken
// again as soon as the last result word sits in the output register. Two
// empty sequences give one result word of kind empty. Configuration writes
// are taken at any time and must only be made while the block is idle.
module global_sequence_alignment_core #(
  parameter int MAX_LEN = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gsa_pkg::IDX_W-1:0]     cfg_index,
  input  logic [gsa_pkg::REG_W-1:0]     cfg_data,
  gsa_item_if.sink                      item,
  gsa_result_if.source                  result
);

  // Sequence lengths count up to MAX_LEN inclusive.
  localparam int LW     = $clog2(MAX_LEN + 1);
  localparam int SAW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int GW     = MAX_LEN + 1;
  localparam int GDEPTH = GW * GW;
  localparam int GAW    = $clog2(GDEPTH);
  localparam int BDEPTH = 2 * MAX_LEN;
  localparam int BAW    = $clog2(BDEPTH);
  localparam int NW     = BAW + 1;
  localparam int BUF_W  = gsa_pkg::KIND_W + gsa_pkg::SYM_W;

  localparam logic [LW-1:0]  LEN_MAX  = LW'(MAX_LEN);
  localparam logic [GAW-1:0] ROW_STEP = GAW'(GW);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROW0,
    S_FILL,
    S_TB,
    S_TB_D,
    S_TB_U,
    S_EMIT_RD,
    S_EMIT,
    S_EMPTY
  } state_t;

  state_t state;

  // Configuration registers.
  logic [gsa_pkg::REG_W-1:0] gap_penalty;
  logic [gsa_pkg::REG_W-1:0] mismatch_penalty;
  logic [gsa_pkg::REG_W-1:0] match_bonus;

  logic [LW-1:0]  len_a;
  logic [LW-1:0]  len_b;

  // Grid walk: i is the row, cj the column; base_cur and base_up are the grid
  // addresses of column zero in rows i and i-1.
  logic [LW-1:0]  i;
  logic [LW-1:0]  cj;
  logic [GAW-1:0] base_cur;
  logic [GAW-1:0] base_up;

  // bnd holds the border value -k*gap of the current row or column.
  gsa_pkg::acc_t  bnd;
  gsa_pkg::acc_t  left;
  gsa_pkg::acc_t  dreg;
  gsa_pkg::acc_t  cur;
  gsa_pkg::score_t score_r;

  logic [NW-1:0]  n;
  logic [BAW-1:0] rd_idx;

  // Output register.
  logic            out_valid;
  gsa_pkg::kind_t  out_kind;
  gsa_pkg::sym_t   out_sym;
  gsa_pkg::score_t out_score;
  logic            out_last;

  // Memory ports.
  logic                        a_we;
  logic                        b_we;
  logic [SAW-1:0]              a_raddr;
  logic [SAW-1:0]              b_raddr;
  gsa_pkg::sym_t               a_rdata;
  gsa_pkg::sym_t               b_rdata;
  logic                        grid_we;
  logic [GAW-1:0]              grid_waddr;
  logic [gsa_pkg::SCORE_W-1:0] grid_wdata;
  logic [GAW-1:0]              grid_raddr;
  logic [gsa_pkg::SCORE_W-1:0] grid_rdata;
  logic                        buf_we;
  logic [BUF_W-1:0]            buf_wdata;
  logic [BUF_W-1:0]            buf_rdata;

  gsa_pkg::unit_op_t  uop;
  gsa_pkg::unit_res_t ures;

  gsa_pkg::acc_t  gap_x;
  gsa_pkg::acc_t  up_x;
  gsa_pkg::acc_t  fill_val;
  logic           accept;
  logic           slot_free;
  logic           load_out;

  assign accept    = item.valid && item.ready;
  assign slot_free = !out_valid || result.ready;
  // A new word enters the output register in this cycle.
  assign load_out  = slot_free && (state == S_EMIT || state == S_EMPTY);
  assign gap_x     = gsa_pkg::acc_t'({1'b0, gap_penalty});
  assign up_x      = $signed({grid_rdata[gsa_pkg::SCORE_W-1], grid_rdata});
  // Column zero of each row takes the border value, every other cell the best.
  assign fill_val  = (cj == '0) ? bnd : ures.best;

  assign item.ready            = (state == S_IDLE);
  assign result.valid          = out_valid;
  assign result.kind           = out_kind;
  assign result.matched_symbol = out_sym;
  assign result.score          = out_score;
  assign result.last           = out_last;

  // The scoring unit serves both the fill (best of three) and the traceback
  // (which neighbor produced the current cell).
  assign uop.a_sym    = a_rdata;
  assign uop.b_sym    = b_rdata;
  assign uop.diag     = dreg;
  assign uop.left     = left;
  assign uop.up       = up_x;
  assign uop.cur      = cur;
  assign uop.gap      = gap_penalty;
  assign uop.mismatch = mismatch_penalty;
  assign uop.bonus    = match_bonus;

  gsa_unit u_unit (
    .op  (uop),
    .res (ures)
  );

  always_comb begin
    a_we       = accept && (item.action == gsa_pkg::ACT_APPEND_A) && (len_a != LEN_MAX);
    b_we       = accept && (item.action == gsa_pkg::ACT_APPEND_B) && (len_b != LEN_MAX);
    a_raddr    = SAW'(i - LW'(1));
    b_raddr    = (state == S_FILL) ? SAW'(cj) : SAW'(cj - LW'(1));
    grid_we    = 1'b0;
    grid_waddr = GAW'(cj);
    grid_wdata = bnd[gsa_pkg::SCORE_W-1:0];
    grid_raddr = base_up + GAW'(cj) + GAW'(1);
    buf_we     = 1'b0;
    buf_wdata  = {gsa_pkg::KIND_GAP_A, gsa_pkg::SYM_W'(0)};
    unique case (state)
      S_ROW0: begin
        grid_we = 1'b1;
      end
      S_FILL: begin
        // The read issued here is for the next column of row i-1.
        grid_we    = 1'b1;
        grid_waddr = base_cur + GAW'(cj);
        grid_wdata = fill_val[gsa_pkg::SCORE_W-1:0];
      end
      S_TB: begin
        grid_raddr = base_up + GAW'(cj) - GAW'(1);
        if (cj != '0 && i == '0) begin
          buf_we = 1'b1;
        end else if (cj == '0 && i != '0) begin
          buf_we    = 1'b1;
          buf_wdata = {gsa_pkg::KIND_GAP_B, gsa_pkg::SYM_W'(0)};
        end
      end
      S_TB_D: begin
        grid_raddr = base_up + GAW'(cj);
      end
      S_TB_U: begin
        buf_we = 1'b1;
        if (ures.diag_hit) begin
          buf_wdata = ures.same ? {gsa_pkg::KIND_MATCH, a_rdata}
                                : {gsa_pkg::KIND_MISMATCH, gsa_pkg::SYM_W'(0)};
        end else if (ures.up_hit) begin
          buf_wdata = {gsa_pkg::KIND_GAP_B, gsa_pkg::SYM_W'(0)};
        end
      end
      default: begin
      end
    endcase
  end

  gsa_ram #(.WIDTH(gsa_pkg::SYM_W), .DEPTH(MAX_LEN)) u_seq_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (SAW'(len_a)),
    .wdata (item.symbol),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  gsa_ram #(.WIDTH(gsa_pkg::SYM_W), .DEPTH(MAX_LEN)) u_seq_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (SAW'(len_b)),
    .wdata (item.symbol),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  gsa_ram #(.WIDTH(gsa_pkg::SCORE_W), .DEPTH(GDEPTH)) u_grid (
    .clk   (clk),
    .we    (grid_we),
    .waddr (grid_waddr),
    .wdata (grid_wdata),
    .raddr (grid_raddr),
    .rdata (grid_rdata)
  );

  gsa_ram #(.WIDTH(BUF_W), .DEPTH(BDEPTH)) u_align (
    .clk   (clk),
    .we    (buf_we),
    .waddr (n[BAW-1:0]),
    .wdata (buf_wdata),
    .raddr (rd_idx),
    .rdata (buf_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      gap_penalty      <= gsa_pkg::REG_W'(1);
      mismatch_penalty <= gsa_pkg::REG_W'(1);
      match_bonus      <= gsa_pkg::REG_W'(1);
      len_a            <= '0;
      len_b            <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gsa_pkg::REG_GAP:      gap_penalty      <= cfg_data;
          gsa_pkg::REG_MISMATCH: mismatch_penalty <= cfg_data;
          gsa_pkg::REG_MATCH:    match_bonus      <= cfg_data;
          default: begin
          end
        endcase
      end

      if (result.ready && !load_out) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (a_we) begin
            len_a <= len_a + LW'(1);
          end
          if (b_we) begin
            len_b <= len_b + LW'(1);
          end
          if (accept && item.action == gsa_pkg::ACT_RUN) begin
            if (len_a == '0 && len_b == '0) begin
              state <= S_EMPTY;
            end else begin
              i     <= '0;
              cj    <= '0;
              bnd   <= '0;
              state <= S_ROW0;
            end
          end
        end

        S_ROW0: begin
          cur <= bnd;
          if (cj == len_b) begin
            n       <= '0;
            score_r <= bnd[gsa_pkg::SCORE_W-1:0];
            if (len_a == '0) begin
              state <= S_TB;
            end else begin
              i        <= LW'(1);
              cj       <= '0;
              base_up  <= '0;
              base_cur <= ROW_STEP;
              bnd      <= -gap_x;
              state    <= S_FILL;
            end
          end else begin
            cj  <= cj + LW'(1);
            bnd <= bnd - gap_x;
          end
        end

        S_FILL: begin
          left <= fill_val;
          cur  <= fill_val;
          // The upper cell becomes the diagonal of the next column.
          dreg <= (cj == '0) ? bnd + gap_x : up_x;
          if (cj == len_b) begin
            if (i == len_a) begin
              n       <= '0;
              score_r <= fill_val[gsa_pkg::SCORE_W-1:0];
              state   <= S_TB;
            end else begin
              i        <= i + LW'(1);
              base_up  <= base_cur;
              base_cur <= base_cur + ROW_STEP;
              bnd      <= bnd - gap_x;
              cj       <= '0;
            end
          end else begin
            cj <= cj + LW'(1);
          end
        end

        S_TB: begin
          if (i != '0 && cj != '0) begin
            state <= S_TB_D;
          end else if (cj != '0) begin
            cj <= cj - LW'(1);
            n  <= n + NW'(1);
          end else if (i != '0) begin
            i <= i - LW'(1);
            n <= n + NW'(1);
          end else begin
            rd_idx <= BAW'(n - NW'(1));
            len_a  <= '0;
            len_b  <= '0;
            state  <= S_EMIT_RD;
          end
        end

        S_TB_D: begin
          dreg  <= up_x;
          state <= S_TB_U;
        end

        S_TB_U: begin
          n     <= n + NW'(1);
          state <= S_TB;
          if (ures.diag_hit) begin
            cur      <= dreg;
            i        <= i - LW'(1);
            cj       <= cj - LW'(1);
            base_cur <= base_up;
            base_up  <= base_up - ROW_STEP;
          end else if (ures.up_hit) begin
            cur      <= up_x;
            i        <= i - LW'(1);
            base_cur <= base_up;
            base_up  <= base_up - ROW_STEP;
          end else begin
            // Only the left neighbor is left: it is the current value plus gap.
            cur <= cur + gap_x;
            cj  <= cj - LW'(1);
          end
        end

        S_EMIT_RD: begin
          state <= S_EMIT;
        end

        S_EMIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_kind  <= buf_rdata[BUF_W-1:gsa_pkg::SYM_W];
            out_sym   <= buf_rdata[gsa_pkg::SYM_W-1:0];
            out_score <= score_r;
            out_last  <= (rd_idx == '0);
            if (rd_idx == '0) begin
              state <= S_IDLE;
            end else begin
              rd_idx <= rd_idx - BAW'(1);
              state  <= S_EMIT_RD;
            end
          end
        end

        S_EMPTY: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_kind  <= gsa_pkg::KIND_EMPTY;
            out_sym   <= '0;
            out_score <= '0;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The traceback never records more positions than the buffer holds.
  a_tb_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_TB_U) |-> (n < NW'(BDEPTH)))
    else $error("alignment buffer overrun in traceback");

  // A finished traceback of a non-empty pair has recorded at least one position.
  a_tb_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_TB && i == '0 && cj == '0) |-> (n != '0))
    else $error("traceback finished with no positions");

  // Once the final word is loaded the sequences have been cleared.
  a_clear_after_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && slot_free && rd_idx == '0) |=> (len_a == '0 && len_b == '0))
    else $error("sequences not cleared after alignment");

  // A loaded result word is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready) |=> (out_valid && $stable(out_kind) && $stable(out_last)))
    else $error("result word lost before handshake");

endmodule
